FILE: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants for the binary GCD block.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // Operand and result width (matches the 32-bit stream fields)
    localparam int WIDTH = 32;

    // Shared power-of-two count: never exceeds WIDTH-1
    localparam int CNT_W = $clog2(WIDTH);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SHIFT
    } gcd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } gcd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic lo_zero;
    } gcd_status_t;

endpackage

FILE: rtl/gcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_dp
// Operand registers, one Stein reduction step per cycle, final shift and
// result register.
// ----------------------------------------------------------------------------
module gcd_dp (
    input  logic                          clk,
    input  logic [gcd_pkg::WIDTH-1:0]     operand_a,
    input  logic [gcd_pkg::WIDTH-1:0]     operand_b,
    input  gcd_pkg::gcd_cmd_t             cmd,
    output gcd_pkg::gcd_status_t          status,
    output logic [gcd_pkg::WIDTH-1:0]     divisor
);
    import gcd_pkg::*;

    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CNT_W-1:0] shared_reg, shared_next;
    logic [WIDTH-1:0] result_reg, result_next;

    logic [WIDTH:0]   diff_ab;
    logic [WIDTH-1:0] diff_ba;
    logic             a_lt_b;
    logic [WIDTH-1:0] min_val;
    logic [WIDTH-1:0] mag;
    logic             any_zero;

    // Compare and difference of the two operands
    assign diff_ab  = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba  = b_reg - a_reg;
    assign a_lt_b   = diff_ab[WIDTH];
    assign min_val  = a_lt_b ? a_reg : b_reg;
    assign mag      = a_lt_b ? diff_ba : diff_ab[WIDTH-1:0];
    assign any_zero = (a_reg == '0) || (b_reg == '0);

    assign status.lo_zero = any_zero;

    // Next-state logic of the datapath
    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        shared_next = shared_reg;
        result_next = result_reg;
        if (cmd.load)
        begin
            a_next      = operand_a;
            b_next      = operand_b;
            shared_next = '0;
        end
        else if (cmd.step)
        begin
            if (any_zero)
            begin
                // smaller operand gone: keep the survivor in a
                a_next = a_reg | b_reg;
                b_next = '0;
            end
            else
            begin
                unique case ({a_reg[0], b_reg[0]})
                    2'b00:
                    begin
                        a_next      = a_reg >> 1;
                        b_next      = b_reg >> 1;
                        shared_next = shared_reg + 1'b1;
                    end
                    2'b01:   a_next = a_reg >> 1;
                    2'b10:   b_next = b_reg >> 1;
                    default:
                    begin
                        // both odd: replace the larger by the difference
                        a_next = mag;
                        b_next = min_val;
                    end
                endcase
            end
        end
        if (cmd.emit)
            result_next = a_reg << shared_reg;
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        shared_reg <= shared_next;
        result_reg <= result_next;
    end

    assign divisor = result_reg;

endmodule

FILE: rtl/gcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_ctrl
// Sequencer for the GCD datapath and the output valid flag.
// ----------------------------------------------------------------------------
module gcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  gcd_pkg::gcd_status_t  status,
    output gcd_pkg::gcd_cmd_t     cmd
);
    import gcd_pkg::*;

    gcd_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // State and output flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.lo_zero)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/binary_gcd_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_gcd_top
// Greatest common divisor of two unsigned operands by the binary method.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transaction carries operand_a in s_tdata[31:0] and
//   operand_b in s_tdata[63:32]. Output stream m_*: one transaction per input
//   carries the divisor in m_tdata[31:0]; gcd(x,0) = x and gcd(0,0) = 0.
//   One item is worked on at a time: s_tready is high only while the block
//   is idle. An item is loaded, then reduced one step per cycle (a halving
//   or a subtraction; no such steps when an operand is zero), then the
//   operands are collapsed into a single value, then the final shift
//   writes the output register once it is free. The shared reduction unit
//   thus takes a new item only after the current one reaches the output
//   register.
//   The result sits in an output register, so the next item is accepted
//   while m_tvalid waits on m_tready; if a result finishes while the
//   previous one is still untaken, the block holds it until m_tready.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   m_tvalid; any item in progress is discarded.
// ----------------------------------------------------------------------------
module binary_gcd_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] operand_a, [63:32] operand_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] divisor
);
    import gcd_pkg::*;

    gcd_cmd_t    cmd;
    gcd_status_t status;

    // Sequencer
    gcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    gcd_dp u_dp (
        .clk       (clk),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .cmd       (cmd),
        .status    (status),
        .divisor   (m_tdata)
    );

endmodule
